// ----- hdl/rwlm_pkg.sv -----
// ----------------------------------------------------------------------------
// rwlm_pkg: shared types and constants of the readers-writer lock manager
// Request and result structs, sizes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package rwlm_pkg;

    localparam int GROUPS      = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int GW          = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int QW          = $clog2(QUEUE_DEPTH);
    localparam int FW          = $clog2(QUEUE_DEPTH + 1);
    localparam int TW          = 33;  // kind, thread, round, reply

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TBL_FULL  = 3'd1;
    localparam logic [2:0] ST_Q_FULL    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_NO_HOLDER = 3'd4;

    typedef struct packed {
        logic        action;
        logic [15:0] group_id;
        logic        kind;
        logic [7:0]  thread_tag;
        logic [15:0] round_tag;
        logic [7:0]  reply_tag;
    } req_t;

    typedef struct packed {
        logic        granted;
        logic [2:0]  status;
        logic [15:0] grant_group;
        logic        grant_kind;
        logic [7:0]  grant_thread;
        logic [15:0] grant_round;
        logic [7:0]  grant_reply;
        logic        last;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_RDHEAD,
        S_TRY,
        S_PEEK,
        S_LOOK,
        S_OUT
    } state_t;

endpackage

// ----- hdl/readers_writer_lock_manager_top.sv -----
// ----------------------------------------------------------------------------
// readers_writer_lock_manager_top: per-group FIFO readers-writer lock manager
// Sequencer over a group table and a ticket memory.
// ----------------------------------------------------------------------------
// Each request is a lock request or a release for one group. A request scans
// the group table one slot a cycle (up to all GROUPS slots), enqueues its
// ticket and tries the head once; a release updates the holder state and then
// grants the head writer or the run of head readers. Each grant passes through
// a ticket memory read, a grant check and a result handoff; a reader grant
// with another ticket behind it also reads the next head to learn whether
// the run goes on and so whether this grant is the last. The block takes one
// request at a time; s_ready is low while it works. Results leave through an
// output register; the last result of each request has last set.
// Reset needs no clearing pass: tickets are only read inside a queue.
module readers_writer_lock_manager_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rwlm_pkg::req_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rwlm_pkg::res_t   m_data
);
    localparam int GW = rwlm_pkg::GW;
    localparam int QW = rwlm_pkg::QW;
    localparam int FW = rwlm_pkg::FW;

    rwlm_pkg::state_t state_reg, state_next;

    // group table
    logic [15:0]   owner_reg   [rwlm_pkg::GROUPS];
    logic [7:0]    readers_reg [rwlm_pkg::GROUPS];
    logic          wbusy_reg   [rwlm_pkg::GROUPS];
    logic [QW-1:0] head_reg    [rwlm_pkg::GROUPS];
    logic [FW-1:0] fill_reg    [rwlm_pkg::GROUPS];

    rwlm_pkg::req_t req_reg;
    logic [GW:0]    idx_reg, idx_next;       // scan counter, one wider
    logic           found_reg, free_ok_reg;
    logic [GW-1:0]  grp_reg, free_reg;
    logic           mode_reg;                // 1: release run of readers
    logic           any_reg;                 // a grant was already emitted
    rwlm_pkg::res_t res_reg;

    // ticket memory
    logic                     t_we;
    logic [GW+QW-1:0]         t_waddr, t_raddr;
    logic [rwlm_pkg::TW-1:0]  t_rdata;

    rwlm_ticket_ram u_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata ({req_reg.kind, req_reg.thread_tag, req_reg.round_tag,
                 req_reg.reply_tag}),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    logic [GW-1:0] sidx;
    logic [QW-1:0] tail;
    logic          tk_kind;
    logic          can_grant;
    logic          try_ok;     // head ticket is granted this try
    logic          run_more;   // reader granted with tickets behind it
    assign sidx    = idx_reg[GW-1:0];
    assign tail    = head_reg[grp_reg] + fill_reg[grp_reg][QW-1:0];
    assign t_waddr = {grp_reg, tail};
    assign t_raddr = {grp_reg, head_reg[grp_reg]};
    assign tk_kind = t_rdata[rwlm_pkg::TW-1];
    assign can_grant = tk_kind ? (!wbusy_reg[grp_reg] && readers_reg[grp_reg] == 8'd0)
                               : !wbusy_reg[grp_reg];
    assign try_ok   = can_grant && (!mode_reg || !any_reg || !tk_kind);
    assign run_more = try_ok && mode_reg && !tk_kind && fill_reg[grp_reg] > FW'(1);

    assign s_ready = (state_reg == rwlm_pkg::S_IDLE);
    assign m_valid = (state_reg == rwlm_pkg::S_OUT);
    assign m_data  = res_reg;

    // control outcome of the decide step
    logic [2:0] dec_status;
    logic       dec_fail, dec_claim;
    always_comb begin
        dec_status = rwlm_pkg::ST_OK;
        dec_fail   = 1'b0;
        dec_claim  = 1'b0;
        if (req_reg.group_id == 16'd0) begin
            dec_fail = 1'b1; dec_status = rwlm_pkg::ST_UNKNOWN;
        end else if (!req_reg.action) begin
            if (!found_reg && !free_ok_reg) begin
                dec_fail = 1'b1; dec_status = rwlm_pkg::ST_TBL_FULL;
            end else begin
                dec_claim = !found_reg;
                if (found_reg && fill_reg[grp_reg] == FW'(rwlm_pkg::QUEUE_DEPTH)) begin
                    dec_fail = 1'b1; dec_status = rwlm_pkg::ST_Q_FULL;
                end
            end
        end else if (!found_reg) begin
            dec_fail = 1'b1; dec_status = rwlm_pkg::ST_UNKNOWN;
        end else if (req_reg.kind ? !wbusy_reg[grp_reg]
                                  : (readers_reg[grp_reg] == 8'd0)) begin
            dec_fail = 1'b1; dec_status = rwlm_pkg::ST_NO_HOLDER;
        end
    end

    assign t_we = (state_reg == rwlm_pkg::S_DECIDE) && !dec_fail && !req_reg.action;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            rwlm_pkg::S_IDLE: begin
                idx_next = '0;
                if (s_valid) state_next = rwlm_pkg::S_SCAN;
            end
            rwlm_pkg::S_SCAN: begin
                idx_next = idx_reg + 1'b1;
                if (req_reg.group_id == 16'd0 || owner_reg[sidx] == req_reg.group_id
                    || idx_reg == (GW+1)'(rwlm_pkg::GROUPS - 1))
                    state_next = rwlm_pkg::S_DECIDE;
            end
            rwlm_pkg::S_DECIDE: begin
                if (dec_fail) state_next = rwlm_pkg::S_OUT;
                else state_next = rwlm_pkg::S_RDHEAD;
            end
            rwlm_pkg::S_RDHEAD: begin
                if (fill_reg[grp_reg] == '0) state_next = rwlm_pkg::S_OUT;
                else state_next = rwlm_pkg::S_TRY;
            end
            rwlm_pkg::S_TRY: begin
                if (run_more) state_next = rwlm_pkg::S_PEEK;
                else state_next = rwlm_pkg::S_OUT;
            end
            rwlm_pkg::S_PEEK: state_next = rwlm_pkg::S_LOOK;
            rwlm_pkg::S_LOOK: state_next = rwlm_pkg::S_OUT;
            rwlm_pkg::S_OUT: begin
                if (m_ready) begin
                    if (res_reg.last) state_next = rwlm_pkg::S_IDLE;
                    else state_next = rwlm_pkg::S_RDHEAD;
                end
            end
            default: state_next = rwlm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rwlm_pkg::S_IDLE;
            for (int i = 0; i < rwlm_pkg::GROUPS; i++) begin
                owner_reg[i]   <= '0;
                readers_reg[i] <= '0;
                wbusy_reg[i]   <= 1'b0;
                head_reg[i]    <= '0;
                fill_reg[i]    <= '0;
            end
            idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            case (state_reg)
                rwlm_pkg::S_DECIDE: begin
                    if (dec_claim) owner_reg[grp_reg] <= req_reg.group_id;
                    if (!dec_fail && !req_reg.action)
                        fill_reg[grp_reg] <= fill_reg[grp_reg] + 1'b1;
                    if (!dec_fail && req_reg.action) begin
                        if (req_reg.kind) wbusy_reg[grp_reg] <= 1'b0;
                        else readers_reg[grp_reg] <= readers_reg[grp_reg] - 1'b1;
                    end
                end
                rwlm_pkg::S_TRY: begin
                    if (try_ok) begin
                        if (tk_kind) wbusy_reg[grp_reg] <= 1'b1;
                        else if (readers_reg[grp_reg] != 8'hFF)
                            readers_reg[grp_reg] <= readers_reg[grp_reg] + 1'b1;
                        head_reg[grp_reg] <= head_reg[grp_reg] + 1'b1;
                        fill_reg[grp_reg] <= fill_reg[grp_reg] - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            rwlm_pkg::S_IDLE: begin
                req_reg     <= s_data;
                found_reg   <= 1'b0;
                free_ok_reg <= 1'b0;
                any_reg     <= 1'b0;
            end
            rwlm_pkg::S_SCAN: begin
                if (owner_reg[sidx] == req_reg.group_id) begin
                    found_reg <= 1'b1;
                    grp_reg   <= sidx;
                end else if (owner_reg[sidx] == 16'd0 && !free_ok_reg) begin
                    free_ok_reg <= 1'b1;
                    free_reg    <= sidx;
                    grp_reg     <= sidx;    // claimed slot unless a match follows
                end
            end
            rwlm_pkg::S_DECIDE: begin
                if (!found_reg) grp_reg <= free_reg;
                mode_reg <= req_reg.action;
                res_reg  <= '{granted: 1'b0, status: dec_status, grant_group: 16'd0,
                              grant_kind: 1'b0, grant_thread: 8'd0, grant_round: 16'd0,
                              grant_reply: 8'd0, last: 1'b1};
            end
            rwlm_pkg::S_RDHEAD: begin
                res_reg <= '{granted: 1'b0, status: rwlm_pkg::ST_OK, grant_group: 16'd0,
                             grant_kind: 1'b0, grant_thread: 8'd0, grant_round: 16'd0,
                             grant_reply: 8'd0, last: 1'b1};
            end
            rwlm_pkg::S_TRY: begin
                if (try_ok) begin
                    any_reg <= 1'b1;
                    res_reg <= '{granted: 1'b1, status: rwlm_pkg::ST_OK,
                                 grant_group: owner_reg[grp_reg], grant_kind: tk_kind,
                                 grant_thread: t_rdata[31:24], grant_round: t_rdata[23:8],
                                 grant_reply: t_rdata[7:0],
                                 last: !run_more};
                end else begin
                    res_reg.last <= 1'b1;
                end
            end
            rwlm_pkg::S_LOOK: begin
                // the run goes on only while the new head is a reader
                res_reg.last <= tk_kind;
            end
            default: ;
        endcase
    end

    // A reader run stops at the first writer; the head after each reader grant
    // is read ahead so the final grant of the run carries last.

    property p_ready_idle;
        @(posedge aclk) disable iff (!aresetn) s_ready |-> !m_valid;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("ready while result pending");

    property p_fill_bound;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == rwlm_pkg::S_TRY) |->
                fill_reg[grp_reg] <= FW'(rwlm_pkg::QUEUE_DEPTH);
    endproperty
    a_fill_bound: assert property (p_fill_bound) else $error("queue fill overflow");

    property p_grant_ok;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && m_data.granted) |-> m_data.status == rwlm_pkg::ST_OK;
    endproperty
    a_grant_ok: assert property (p_grant_ok) else $error("grant with error status");
endmodule

// ----- hdl/rwlm_ticket_ram.sv -----
// ----------------------------------------------------------------------------
// rwlm_ticket_ram: ticket store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rwlm_ticket_ram (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [rwlm_pkg::GW+rwlm_pkg::QW-1:0] waddr,
    input  logic [rwlm_pkg::TW-1:0]             wdata,
    input  logic [rwlm_pkg::GW+rwlm_pkg::QW-1:0] raddr,
    output logic [rwlm_pkg::TW-1:0]             rdata
);
    logic [rwlm_pkg::TW-1:0] mem [rwlm_pkg::GROUPS*rwlm_pkg::QUEUE_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
